FILE: design/led_dimmer_soft_ramp_gamma_core_defines.svh
// Assertion macros used by the dimmer core module ldsr_ctrl.
// Bodies are empty in synthesis builds; no other dependencies.
`ifndef LED_DIMMER_SOFT_RAMP_GAMMA_CORE_DEFINES_SVH
`define LED_DIMMER_SOFT_RAMP_GAMMA_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define LDSR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define LDSR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LDSR_ASSERT(lbl, prop, msg)
`define LDSR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: design/ldsr_pkg.sv
// Types, codes and the gamma table of the LED dimmer core.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps

package ldsr_pkg;

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_TURN  = 3'd1,
		OP_CLICK = 3'd2,
		OP_ON    = 3'd3,
		OP_OFF   = 3'd4,
		OP_SET   = 3'd5
	} op_t;

	localparam logic [7:0] CFG_RAMP_WAIT   = 8'd0;
	localparam logic [7:0] CFG_REPORT_WAIT = 8'd1;

	localparam logic [15:0] RAMP_WAIT_RESET   = 16'd20;
	localparam logic [15:0] REPORT_WAIT_RESET = 16'd200;
	localparam logic [6:0]  SETPOINT_RESET    = 7'd100;
	localparam logic [6:0]  GAMMA_TOP         = 7'd100;

	typedef struct packed {
		logic [6:0] current;
		logic [6:0] setpoint;
		logic       lamp_on;
		logic       rep_valid;
		logic [6:0] rep_level;
	} ldsr_res_t;

	localparam logic [9:0] GAMMA_ROM [0:100] = '{
		10'd0,
		10'd2,   10'd3,   10'd4,   10'd5,   10'd6,   10'd7,   10'd8,   10'd9,   10'd10,  10'd11,
		10'd12,  10'd13,  10'd14,  10'd15,  10'd16,  10'd17,  10'd19,  10'd21,  10'd24,  10'd27,
		10'd29,  10'd32,  10'd36,  10'd39,  10'd42,  10'd46,  10'd50,  10'd54,  10'd59,  10'd63,
		10'd68,  10'd73,  10'd78,  10'd83,  10'd89,  10'd94,  10'd100, 10'd107, 10'd113, 10'd120,
		10'd127, 10'd134, 10'd141, 10'd149, 10'd157, 10'd165, 10'd173, 10'd182, 10'd190, 10'd199,
		10'd209, 10'd218, 10'd228, 10'd238, 10'd249, 10'd259, 10'd270, 10'd281, 10'd293, 10'd305,
		10'd317, 10'd329, 10'd342, 10'd354, 10'd368, 10'd381, 10'd395, 10'd409, 10'd423, 10'd438,
		10'd452, 10'd468, 10'd483, 10'd499, 10'd515, 10'd532, 10'd548, 10'd565, 10'd583, 10'd600,
		10'd618, 10'd637, 10'd655, 10'd674, 10'd694, 10'd713, 10'd733, 10'd753, 10'd774, 10'd795,
		10'd816, 10'd838, 10'd860, 10'd882, 10'd905, 10'd928, 10'd951, 10'd975, 10'd999, 10'd1023
	};

endpackage

FILE: design/ldsr_gamma.sv
// Gamma lookup: brightness level to 10-bit PWM duty.
// Depends on ldsr_pkg for the table.
`timescale 1ns / 1ps

module ldsr_gamma
	import ldsr_pkg::*;
(
	input  logic [6:0] level,
	output logic [9:0] duty
);

	logic [6:0] idx;

	// clamp levels above the table to its last entry
	assign idx  = (level > GAMMA_TOP) ? GAMMA_TOP : level;
	assign duty = GAMMA_ROM[idx];

endmodule

FILE: design/ldsr_ctrl.sv
// Dimmer state: setpoint, lamp flag, soft ramp and report limiter.
// Depends on ldsr_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "led_dimmer_soft_ramp_gamma_core_defines.svh"

module ldsr_ctrl
	import ldsr_pkg::*;
#(
	parameter int MAX_LEVEL  = 100,
	parameter int TIMER_BITS = 16
)
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              upd,
	input  op_t               op,
	input  logic signed [3:0] step,
	input  logic [7:0]        level,
	input  logic [15:0]       ramp_wait,
	input  logic [15:0]       report_wait,
	output ldsr_res_t         res
);

	localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
	localparam logic [6:0] MAX_L = 7'(MAX_LEVEL);

	logic [6:0]            current_q, setpoint_q, last_rep_q;
	logic                  lamp_on_q, by_enc_q;
	logic [TIMER_BITS-1:0] ramp_el_q, rep_el_q;

	logic [6:0]            current_n, setpoint_n, last_rep_n, goal, turn_val;
	logic                  lamp_on_n, by_enc_n, rep;
	logic [TIMER_BITS-1:0] ramp_el_n, rep_el_n, ramp_inc, rep_inc;
	logic signed [8:0]     sum;

	assign ramp_inc = (&ramp_el_q) ? ramp_el_q : ramp_el_q + 1'b1;
	assign rep_inc  = (&rep_el_q) ? rep_el_q : rep_el_q + 1'b1;
	assign goal     = lamp_on_q ? setpoint_q : 7'd0;
	assign sum      = $signed({2'b00, setpoint_q}) + $signed({{5{step[3]}}, step});

	always_comb begin
		if (sum[8]) begin
			turn_val = 7'd0;
		end else if (sum[7:0] > {1'b0, MAX_L}) begin
			turn_val = MAX_L;
		end else begin
			turn_val = sum[6:0];
		end
	end

	always_comb begin
		current_n  = current_q;
		setpoint_n = setpoint_q;
		lamp_on_n  = lamp_on_q;
		by_enc_n   = by_enc_q;
		ramp_el_n  = ramp_el_q;
		rep_el_n   = rep_el_q;
		case (op)
			OP_TICK: begin
				ramp_el_n = ramp_inc;
				rep_el_n  = rep_inc;
				if (goal != current_q && CW'(ramp_inc) > CW'(ramp_wait)) begin
					ramp_el_n = '0;
					current_n = (goal > current_q) ? current_q + 7'd1 : current_q - 7'd1;
				end
			end
			OP_TURN: begin
				if (turn_val != setpoint_q) begin
					setpoint_n = turn_val;
					by_enc_n   = 1'b1;
				end
			end
			OP_CLICK: lamp_on_n = !lamp_on_q;
			OP_ON:    lamp_on_n = 1'b1;
			OP_OFF:   lamp_on_n = 1'b0;
			OP_SET: begin
				setpoint_n = (level > {1'b0, MAX_L}) ? MAX_L : level[6:0];
				by_enc_n   = 1'b0;
			end
			default: ;
		endcase
		rep        = by_enc_n && (CW'(rep_el_n) > CW'(report_wait)) && (setpoint_n != last_rep_q);
		last_rep_n = rep ? setpoint_n : last_rep_q;
		if (rep) begin
			rep_el_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_q  <= 7'd0;
			setpoint_q <= SETPOINT_RESET;
			last_rep_q <= SETPOINT_RESET;
			lamp_on_q  <= 1'b1;
			by_enc_q   <= 1'b0;
			ramp_el_q  <= '0;
			rep_el_q   <= '0;
		end else if (upd) begin
			current_q  <= current_n;
			setpoint_q <= setpoint_n;
			last_rep_q <= last_rep_n;
			lamp_on_q  <= lamp_on_n;
			by_enc_q   <= by_enc_n;
			ramp_el_q  <= ramp_el_n;
			rep_el_q   <= rep_el_n;
		end
	end

	assign res.current   = current_n;
	assign res.setpoint  = setpoint_n;
	assign res.lamp_on   = lamp_on_n;
	assign res.rep_valid = rep;
	assign res.rep_level = rep ? setpoint_n : 7'd0;

	`LDSR_ASSERT_ALWAYS(a_reset_dark, !arst_n |-> current_q == 7'd0, "level not dark in reset")
	`LDSR_ASSERT(a_ramp_one_step, current_q == $past(current_q) || current_q == $past(current_q) + 7'd1 || current_q == $past(current_q) - 7'd1, "level moved by more than one step")
	`LDSR_ASSERT(a_report_latch, upd && rep |=> last_rep_q == setpoint_q && rep_el_q == '0, "report did not latch setpoint")
	`LDSR_ASSERT(a_hold_idle, !upd |=> $stable(setpoint_q) && $stable(current_q), "state changed without an item")

endmodule

FILE: design/led_dimmer_soft_ramp_gamma_core.sv
// LED dimmer core: one result word per input word, one word per clock sustained
// while the output is not stalled. A word passes the input register and then the
// result register, which offers it as a result; the state update between them is
// combinational and is stored as the word moves into the result register. Both
// sides may stall freely. Configuration writes are taken at any time and should be
// made while no word is in flight.
// Depends on ldsr_pkg, ldsr_ctrl and ldsr_gamma.
`timescale 1ns / 1ps

module led_dimmer_soft_ramp_gamma_core
	import ldsr_pkg::*;
#(
	parameter int MAX_LEVEL  = 100,
	parameter int TIMER_BITS = 16
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // step[3:0], level[11:4], zero[15:12]
	input  logic [2:0]  s_tuser,   // op[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // duty[9:0], current_out[16:10], setpoint_out[23:17],
	                               // lamp_on_out[24], report_level[31:25]
	output logic        m_tuser,   // report_valid[0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic              valid_s1, valid_s2, upd, adv_s2;
	op_t               op_s1;
	logic signed [3:0] step_s1;
	logic [7:0]        level_s1;
	logic [15:0]       ramp_wait_q, report_wait_q;
	ldsr_res_t         res, res_s2;
	logic [9:0]        duty, duty_s2;

	assign adv_s2    = !valid_s2 || m_tready;
	assign upd       = valid_s1 && adv_s2;
	assign s_tready  = !valid_s1 || adv_s2;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_wait_q   <= RAMP_WAIT_RESET;
			report_wait_q <= REPORT_WAIT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_RAMP_WAIT:   ramp_wait_q   <= cfg_data;
				CFG_REPORT_WAIT: report_wait_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1    <= op_t'(s_tuser);
			step_s1  <= s_tdata[3:0];
			level_s1 <= s_tdata[11:4];
		end
		if (upd) begin
			res_s2  <= res;
			duty_s2 <= duty;
		end
	end

	ldsr_ctrl #(
		.MAX_LEVEL  (MAX_LEVEL),
		.TIMER_BITS (TIMER_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (upd),
		.op          (op_s1),
		.step        (step_s1),
		.level       (level_s1),
		.ramp_wait   (ramp_wait_q),
		.report_wait (report_wait_q),
		.res         (res)
	);

	ldsr_gamma u_gamma (
		.level (res.current),
		.duty  (duty)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {res_s2.rep_level, res_s2.lamp_on, res_s2.setpoint, res_s2.current, duty_s2};
	assign m_tuser  = res_s2.rep_valid;

endmodule

FILE: tb/tb_led_dimmer_soft_ramp_gamma_core.sv
// Self-checking bench for the LED dimmer core: a directed table, then random phases of dimmer
// events under several register settings, each result word checked against a local model or a pinned word.
// Depends on ldsr_pkg and the led_dimmer_soft_ramp_gamma_core RTL.
`timescale 1ns / 1ps

module tb_led_dimmer_soft_ramp_gamma_core;
	import ldsr_pkg::*;

	localparam int LEVEL_MAX   = 100;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 150;
	localparam int PHASES      = 6;
	localparam int PHASE_WORDS = 90;

	localparam logic [2:0] OP_SPARE6 = 3'd6;
	localparam logic [2:0] OP_SPARE7 = 3'd7;

	localparam logic [3:0] STEP_P1 = 4'd1;
	localparam logic [3:0] STEP_P5 = 4'd5;
	localparam logic [3:0] STEP_P7 = 4'd7;
	localparam logic [3:0] STEP_M1 = 4'b1111;
	localparam logic [3:0] STEP_M5 = 4'b1011;
	localparam logic [3:0] STEP_M8 = 4'b1000;

	typedef struct packed {
		logic [9:0] duty;
		logic [6:0] current;
		logic [6:0] setpoint;
		logic       lamp_on;
		logic       rep_valid;
		logic [6:0] rep_level;
	} dimmer_word_t;

	typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

	typedef struct packed {
		row_kind_e    kind;
		logic [2:0]   op;
		logic [3:0]   stp;
		logic [7:0]   lvl;
		logic         pin;
		dimmer_word_t res;
		logic [7:0]   idx;
		logic [15:0]  val;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_index;
	logic [15:0] cfg_data;

	logic         pin_now;
	dimmer_word_t pin_word;

	// model state
	logic [6:0]  lvl_now;
	logic [6:0]  sp;
	logic        lamp;
	logic        enc_flag;
	logic [6:0]  last_rep;
	logic [15:0] ramp_cnt;
	logic [15:0] rep_cnt;
	logic [15:0] ramp_wait_r;
	logic [15:0] rep_wait_r;

	dimmer_word_t due_words[$];
	plan_row_t    plan[$];

	int errors;
	int words_in;
	int results_seen;
	int reports_seen;
	int reg_writes;
	int quiet;
	int burst_left;
	int held_cycles;

	led_dimmer_soft_ramp_gamma_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic dimmer_word_t dimmer_apply(input logic [2:0] op, input logic [3:0] stp,
			input logic [7:0] lvl);
		dimmer_word_t w;
		logic [6:0]   goal;
		int           nv;
		w = '0;
		case (op)
			OP_TICK: begin
				goal = lamp ? sp : 7'd0;
				ramp_cnt = sat_inc(ramp_cnt);
				rep_cnt = sat_inc(rep_cnt);
				if (goal != lvl_now && ramp_cnt > ramp_wait_r) begin
					ramp_cnt = '0;
					lvl_now = (goal > lvl_now) ? lvl_now + 7'd1 : lvl_now - 7'd1;
				end
			end
			OP_TURN: begin
				nv = int'(sp) + int'($signed(stp));
				if (nv < 0)
					nv = 0;
				if (nv > LEVEL_MAX)
					nv = LEVEL_MAX;
				if (7'(nv) != sp) begin
					sp = 7'(nv);
					enc_flag = 1'b1;
				end
			end
			OP_CLICK: lamp = !lamp;
			OP_ON: lamp = 1'b1;
			OP_OFF: lamp = 1'b0;
			OP_SET: begin
				sp = (lvl > LEVEL_MAX) ? 7'(LEVEL_MAX) : lvl[6:0];
				enc_flag = 1'b0;
			end
			default: ;
		endcase
		if (enc_flag && rep_cnt > rep_wait_r && sp != last_rep) begin
			rep_cnt = '0;
			last_rep = sp;
			w.rep_valid = 1'b1;
			w.rep_level = sp;
		end
		w.duty = GAMMA_ROM[(lvl_now > GAMMA_TOP) ? GAMMA_TOP : lvl_now];
		w.current = lvl_now;
		w.setpoint = sp;
		w.lamp_on = lamp;
		return w;
	endfunction

	task automatic compare_word(input dimmer_word_t want, input dimmer_word_t got);
		if (got.duty !== want.duty) begin
			errors++;
			$error("duty: expected %0d, got %0d", want.duty, got.duty);
		end
		if (got.current !== want.current) begin
			errors++;
			$error("current_out: expected %0d, got %0d", want.current, got.current);
		end
		if (got.setpoint !== want.setpoint) begin
			errors++;
			$error("setpoint_out: expected %0d, got %0d", want.setpoint, got.setpoint);
		end
		if (got.lamp_on !== want.lamp_on) begin
			errors++;
			$error("lamp_on_out: expected %0d, got %0d", want.lamp_on, got.lamp_on);
		end
		if (got.rep_valid !== want.rep_valid) begin
			errors++;
			$error("report_valid: expected %0d, got %0d", want.rep_valid, got.rep_valid);
		end
		if (got.rep_level !== want.rep_level) begin
			errors++;
			$error("report_level: expected %0d, got %0d", want.rep_level, got.rep_level);
		end
	endtask

	always @(posedge clk) begin
		dimmer_word_t got;
		dimmer_word_t calc;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got.duty = m_tdata[9:0];
				got.current = m_tdata[16:10];
				got.setpoint = m_tdata[23:17];
				got.lamp_on = m_tdata[24];
				got.rep_level = m_tdata[31:25];
				got.rep_valid = m_tuser;
				results_seen++;
				if (got.rep_valid)
					reports_seen++;
				if (due_words.size() == 0) begin
					errors++;
					$error("result word with nothing due: %h", m_tdata);
				end else begin
					compare_word(due_words.pop_front(), got);
				end
			end
			if (s_tvalid && s_tready) begin
				calc = dimmer_apply(s_tuser, s_tdata[3:0], s_tdata[11:4]);
				due_words.push_back(pin_now ? pin_word : calc);
				words_in++;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_RAMP_WAIT)
					ramp_wait_r = cfg_data;
				else if (cfg_index == CFG_REPORT_WAIT)
					rep_wait_r = cfg_data;
				reg_writes++;
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
				$display("led_dimmer_soft_ramp_gamma_core: mismatch");
				$finish;
			end
		end
	end

	// receiver: steps through four ready patterns in turn, plus one long hold-off
	initial begin : receiver
		int cyc;
		int hold_left;
		bit held;
		cyc = 0;
		hold_left = 0;
		held = 1'b0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			cyc++;
			if (!held && words_in >= 250) begin
				held = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				held_cycles++;
				m_tready <= 1'b0;
			end else begin
				case ((cyc / 64) % 4)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 3) != 0);
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= (cyc % 5 != 0);
				endcase
			end
		end
	end

	function automatic void plan_word(input logic [2:0] op, input logic [3:0] stp,
			input logic [7:0] lvl);
		plan_row_t row;
		row = '0;
		row.kind = ROW_WORD;
		row.op = op;
		row.stp = stp;
		row.lvl = lvl;
		plan.push_back(row);
	endfunction

	function automatic void plan_pinned(input logic [2:0] op, input logic [3:0] stp,
			input logic [7:0] lvl, input logic [9:0] duty, input logic [6:0] cur,
			input logic [6:0] spv, input logic on);
		plan_row_t row;
		row = '0;
		row.kind = ROW_WORD;
		row.op = op;
		row.stp = stp;
		row.lvl = lvl;
		row.pin = 1'b1;
		row.res.duty = duty;
		row.res.current = cur;
		row.res.setpoint = spv;
		row.res.lamp_on = on;
		plan.push_back(row);
	endfunction

	function automatic void plan_reg(input logic [7:0] idx, input logic [15:0] val);
		plan_row_t row;
		row = '0;
		row.kind = ROW_REG;
		row.idx = idx;
		row.val = val;
		plan.push_back(row);
	endfunction

	task automatic offer_word(input logic [2:0] op, input logic [3:0] stp, input logic [7:0] lvl,
			input logic pin, input dimmer_word_t pres);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {4'd0, lvl, stp};
		pin_now <= pin;
		pin_word <= pres;
		do @(posedge clk); while (!s_tready);
	endtask

	// drop valid, let every due word drain, then allow the pipeline to settle
	task automatic quiesce();
		@(negedge clk);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (due_words.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : main
		logic [2:0]  op;
		logic [3:0]  stp;
		logic [7:0]  lvl;
		logic [15:0] rw;
		logic [15:0] pw;
		int          r;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pin_now = 1'b0;
		pin_word = '0;
		errors = 0;
		words_in = 0;
		results_seen = 0;
		reports_seen = 0;
		reg_writes = 0;
		quiet = 0;
		burst_left = 0;
		held_cycles = 0;
		lvl_now = '0;
		sp = SETPOINT_RESET;
		lamp = 1'b1;
		enc_flag = 1'b0;
		last_rep = SETPOINT_RESET;
		ramp_cnt = '0;
		rep_cnt = '0;
		ramp_wait_r = RAMP_WAIT_RESET;
		rep_wait_r = REPORT_WAIT_RESET;

		// reset state, saturation at both ends, lamp control, spare ops
		plan_pinned(OP_TICK, 4'd0, 8'd0, 10'd0, 7'd0, 7'd100, 1'b1);
		plan_pinned(OP_SET, 4'd0, 8'd255, 10'd0, 7'd0, 7'd100, 1'b1);
		plan_pinned(OP_SET, 4'd0, 8'd101, 10'd0, 7'd0, 7'd100, 1'b1);
		plan_pinned(OP_SET, 4'd0, 8'd0, 10'd0, 7'd0, 7'd0, 1'b1);
		plan_pinned(OP_TURN, STEP_M5, 8'hFF, 10'd0, 7'd0, 7'd0, 1'b1);
		plan_pinned(OP_TURN, STEP_M8, 8'd0, 10'd0, 7'd0, 7'd0, 1'b1);
		plan_pinned(OP_TURN, STEP_P7, 8'd0, 10'd0, 7'd0, 7'd7, 1'b1);
		plan_word(OP_TURN, 4'd0, 8'd0);
		plan_pinned(OP_OFF, 4'd0, 8'd0, 10'd0, 7'd0, 7'd7, 1'b0);
		plan_pinned(OP_CLICK, 4'd0, 8'd0, 10'd0, 7'd0, 7'd7, 1'b1);
		plan_word(OP_CLICK, 4'd0, 8'd0);
		plan_word(OP_ON, 4'd0, 8'd0);
		plan_word(OP_SPARE6, 4'hF, 8'hAA);
		plan_word(OP_SPARE7, 4'h5, 8'h55);
		// no wait at all: ramp every tick, report a turn once a tick has passed since the last report
		plan_reg(CFG_RAMP_WAIT, 16'd0);
		plan_reg(CFG_REPORT_WAIT, 16'd0);
		plan_word(OP_TICK, 4'd0, 8'd0);
		plan_word(OP_TURN, STEP_P5, 8'd0);
		plan_word(OP_TICK, 4'd0, 8'd0);
		plan_word(OP_SET, 4'd0, 8'd100);
		plan_word(OP_TURN, STEP_P5, 8'd0);
		plan_word(OP_TURN, STEP_M1, 8'd0);
		plan_word(OP_TICK, 4'd0, 8'd0);
		// counter maximum: nothing ramps, nothing reports
		plan_reg(CFG_RAMP_WAIT, 16'hFFFF);
		plan_reg(CFG_REPORT_WAIT, 16'hFFFF);
		plan_word(OP_TICK, 4'd0, 8'd0);
		plan_word(OP_TURN, STEP_M5, 8'd0);
		plan_word(OP_TICK, 4'd0, 8'd0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_REG) begin
				quiesce();
				write_reg(plan[i].idx, plan[i].val);
			end else begin
				offer_word(plan[i].op, plan[i].stp, plan[i].lvl, plan[i].pin, plan[i].res);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					rw = 16'd0;
					pw = 16'd0;
				end
				1: begin
					rw = 16'hFFFF;
					pw = 16'hFFFF;
				end
				2: begin
					rw = 16'($urandom);
					pw = 16'($urandom);
				end
				3: begin
					rw = 16'd1;
					pw = 16'($urandom_range(0, 10));
				end
				4: begin
					rw = 16'($urandom_range(0, 3));
					pw = 16'($urandom_range(0, 40));
				end
				default: begin
					rw = 16'd0;
					pw = 16'($urandom_range(0, 5));
				end
			endcase
			quiesce();
			write_reg(CFG_RAMP_WAIT, rw);
			write_reg(CFG_REPORT_WAIT, pw);
			if (ph == 2 || ph == 4)
				write_reg(8'($urandom_range(2, 255)), 16'($urandom));
			repeat (PHASE_WORDS) begin
				stp = 4'($urandom);
				lvl = 8'($urandom);
				r = $urandom_range(0, 99);
				if (r < 45) begin
					op = OP_TICK;
				end else if (r < 70) begin
					op = OP_TURN;
					if ($urandom_range(0, 4) != 0) begin
						case ($urandom_range(0, 3))
							0: stp = STEP_P1;
							1: stp = STEP_M1;
							2: stp = STEP_P5;
							default: stp = STEP_M5;
						endcase
					end
				end else if (r < 76) begin
					op = OP_CLICK;
				end else if (r < 80) begin
					op = OP_ON;
				end else if (r < 84) begin
					op = OP_OFF;
				end else if (r < 95) begin
					op = OP_SET;
					if ($urandom_range(0, 1) == 0)
						lvl = 8'($urandom_range(0, LEVEL_MAX));
				end else begin
					op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
				end
				offer_word(op, stp, lvl, 1'b0, '0);
			end
		end

		quiesce();
		repeat (8) @(posedge clk);
		if (due_words.size() != 0) begin
			errors++;
			$error("%0d result words never arrived", due_words.size());
		end
		$display("covered %0d event words over %0d register writes, %0d results checked",
			words_in, reg_writes, results_seen);
		$display("%0d setpoint reports seen, output held off %0d cycles once",
			reports_seen, held_cycles);
		if (errors == 0)
			$display("led_dimmer_soft_ramp_gamma_core: match");
		else
			$display("led_dimmer_soft_ramp_gamma_core: mismatch");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/ldsr_pkg.sv
design/ldsr_gamma.sv
design/ldsr_ctrl.sv
design/led_dimmer_soft_ramp_gamma_core.sv
tb/tb_led_dimmer_soft_ramp_gamma_core.sv
